// ===== rtl/cbd_pkg.sv =====
package cbd_pkg;

  localparam int DITHER_DEPTH = 256;
  localparam int DITHER_AW    = $clog2(DITHER_DEPTH);

  // request kinds
  localparam logic KIND_TABLE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // coverage codes
  localparam logic [1:0] COV_NONE    = 2'd0;
  localparam logic [1:0] COV_HALF    = 2'd1;
  localparam logic [1:0] COV_QUARTER = 2'd2;
  localparam logic [1:0] COV_FULL    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_INK_RED   = 2'd0;
  localparam logic [1:0] REG_INK_GREEN = 2'd1;
  localparam logic [1:0] REG_INK_BLUE  = 2'd2;

  // dither guard limits
  localparam logic [7:0] R_LIMIT = 8'd249;
  localparam logic [7:0] G_LIMIT = 8'd253;
  localparam logic [7:0] B_LIMIT = 8'd249;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ink_t;

  typedef struct packed {
    logic [15:0] background;
    logic [1:0]  coverage;
  } pix_req_t;

endpackage

// ===== rtl/cbd_dither_ram.sv =====
module cbd_dither_ram
  import cbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [DITHER_AW-1:0] wr_addr,
  input  logic [7:0]           wr_data,
  input  logic                 rd_en,
  input  logic [DITHER_AW-1:0] rd_addr,
  output logic [7:0]           rd_data
);

  logic [7:0]              mem [DITHER_DEPTH];
  logic [DITHER_DEPTH-1:0] valid_r;
  logic [7:0]              mem_rd_r;
  logic                    vld_rd_r;

  // storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // per-entry valid bits; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = vld_rd_r ? mem_rd_r : 8'd0;

`ifndef SYNTHESIS
  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(wr_addr)])
    else $error("written entry not marked valid");

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("table read and write in one cycle");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_rd_r |-> rd_data == 8'd0)
    else $error("unwritten entry read non-zero");
`endif

endmodule

// ===== rtl/cbd_blend.sv =====
module cbd_blend
  import cbd_pkg::*;
(
  input  pix_req_t    req,
  input  ink_t        ink,
  input  logic [7:0]  dither,
  output logic [15:0] pixel
);

  logic [7:0] bg_r, bg_g, bg_b;
  logic [7:0] ink_r_q, ink_g_q, ink_b_q;
  logic [7:0] mix_r, mix_g, mix_b;
  logic [7:0] dit_r, dit_g, dit_b;

  // widen RGB565 to 8-bit channels, low bits zero
  assign bg_r = {req.background[15:11], 3'b000};
  assign bg_g = {req.background[10:5], 2'b00};
  assign bg_b = {req.background[4:0], 3'b000};

  assign ink_r_q = {2'b00, ink.red[7:2]};
  assign ink_g_q = {2'b00, ink.green[7:2]};
  assign ink_b_q = {2'b00, ink.blue[7:2]};

  // sums peak at 253, so 8 bits hold them
  always_comb begin
    case (req.coverage)
      COV_HALF: begin
        mix_r = {1'b0, bg_r[7:1]} + {1'b0, ink.red[7:1]};
        mix_g = {1'b0, bg_g[7:1]} + {1'b0, ink.green[7:1]};
        mix_b = {1'b0, bg_b[7:1]} + {1'b0, ink.blue[7:1]};
      end
      COV_QUARTER: begin
        mix_r = {2'b00, bg_r[7:2]} + ink_r_q + {ink_r_q[6:0], 1'b0};
        mix_g = {2'b00, bg_g[7:2]} + ink_g_q + {ink_g_q[6:0], 1'b0};
        mix_b = {2'b00, bg_b[7:2]} + ink_b_q + {ink_b_q[6:0], 1'b0};
      end
      default: begin
        mix_r = ink.red;
        mix_g = ink.green;
        mix_b = ink.blue;
      end
    endcase
  end

  // guarded offsets never wrap
  assign dit_r = (mix_r < R_LIMIT) ? mix_r + {5'd0, dither[2:0]} : mix_r;
  assign dit_g = (mix_g < G_LIMIT) ? mix_g + {6'd0, dither[4:3]} : mix_g;
  assign dit_b = (mix_b < B_LIMIT) ? mix_b + {5'd0, dither[7:5]} : mix_b;

  assign pixel = (req.coverage == COV_NONE) ? req.background
                                            : {dit_r[7:3], dit_g[7:2], dit_b[7:3]};

endmodule

// ===== rtl/coverage_blend_dither_rgb565_core.sv =====
// A pixel request has its table byte registered at the accepting edge, is
// blended into the output register once that register is free, and is then
// offered on out_pixel until taken.
// Throughput: one request per cycle while in_stall is low, table writes and
// pixels alike; a table write completes at acceptance and gives no result.
// Reset (rst_n low, synchronous): pipeline empties, ink colour goes to white,
// every dither table entry reads as zero until written.
module coverage_blend_dither_rgb565_core
  import cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_table_slot,
  input  logic [7:0]  in_table_byte,
  input  logic [15:0] in_background,
  input  logic [1:0]  in_coverage,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel
);

  ink_t       ink_r;
  logic       s1_valid_r;
  pix_req_t   s1_req_r;
  logic       out_valid_r;
  logic [15:0] out_pixel_r;

  logic       in_acc;
  logic       out_free;
  logic       s1_adv;
  logic       tbl_wr;
  logic       tbl_rd;
  logic [DITHER_AW-1:0] tbl_rd_addr;
  logic [7:0] dither;
  logic [15:0] blend_pixel;

  // --------------------------------------------------------------------
  // Configuration: ink colour, ignored beyond the three registers
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ink_r <= '{red: 8'hff, green: 8'hff, blue: 8'hff};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INK_RED:   ink_r.red   <= cfg_wdata;
        REG_INK_GREEN: ink_r.green <= cfg_wdata;
        REG_INK_BLUE:  ink_r.blue  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------
  // Flow control. The output register frees when empty or taken; stage 1
  // moves on whenever the output register can load. A request is held off
  // only while a pixel sits in stage 1 that cannot move.
  // --------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // table write at acceptance; pixel reads its entry in the same edge, so a
  // write followed by a pixel on the next cycle already sees the new byte
  assign tbl_wr      = in_acc && (in_kind == KIND_TABLE);
  assign tbl_rd      = in_acc && (in_kind == KIND_PIXEL);
  assign tbl_rd_addr = {in_row[4:0], 3'b000} + in_col;   // (8*row+col) mod 256

  cbd_dither_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr),
    .wr_addr (in_table_slot),
    .wr_data (in_table_byte),
    .rd_en   (tbl_rd),
    .rd_addr (tbl_rd_addr),
    .rd_data (dither)
  );

  // --------------------------------------------------------------------
  // Stage 1: pixel request alongside the registered table byte
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (tbl_rd) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_rd) begin
      s1_req_r <= '{background: in_background, coverage: in_coverage};
    end
  end

  cbd_blend u_blend (
    .req    (s1_req_r),
    .ink    (ink_r),
    .dither (dither),
    .pixel  (blend_pixel)
  );

  // --------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel_r <= blend_pixel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("request stalled with room in the pipeline");

  a_pixel_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_rd |=> s1_valid_r)
    else $error("accepted pixel lost before stage 1");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a pixel in stage 1");

  a_zero_cov_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_req_r.coverage == COV_NONE)
      |=> out_pixel_r == $past(s1_req_r.background))
    else $error("zero coverage did not keep the background");
`endif

endmodule
